// ----- sv/c8alu_pkg.sv -----
// c8alu_pkg: shared types, operation codes and flag helpers for the 8-bit alu
// used by c8alu_core and cpu8_alu_with_flags_unit; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package c8alu_pkg;

    localparam int unsigned OP_W   = 5;
    localparam int unsigned WORD_W = 16;
    localparam int unsigned BYTE_W = 8;
    localparam int unsigned BIT_W  = 3;

    typedef enum logic [OP_W-1:0] {
        OP_ADD   = 5'd0,
        OP_ADC   = 5'd1,
        OP_SUB   = 5'd2,
        OP_SBC   = 5'd3,
        OP_AND   = 5'd4,
        OP_OR    = 5'd5,
        OP_XOR   = 5'd6,
        OP_CP    = 5'd7,
        OP_INC   = 5'd8,
        OP_DEC   = 5'd9,
        OP_NEG   = 5'd10,
        OP_CPL   = 5'd11,
        OP_DAA   = 5'd12,
        OP_RLC   = 5'd13,
        OP_RRC   = 5'd14,
        OP_RL    = 5'd15,
        OP_RR    = 5'd16,
        OP_SLA   = 5'd17,
        OP_SRA   = 5'd18,
        OP_SLL   = 5'd19,
        OP_SRL   = 5'd20,
        OP_RLCA  = 5'd21,
        OP_RRCA  = 5'd22,
        OP_RLA   = 5'd23,
        OP_RRA   = 5'd24,
        OP_BIT   = 5'd25,
        OP_RES   = 5'd26,
        OP_SET   = 5'd27,
        OP_CCF   = 5'd28,
        OP_ADD16 = 5'd29,
        OP_ADC16 = 5'd30,
        OP_SBC16 = 5'd31
    } t_alu_op;

    // flag bit positions
    localparam int unsigned FLAG_S = 7;
    localparam int unsigned FLAG_Z = 6;
    localparam int unsigned FLAG_Y = 5;
    localparam int unsigned FLAG_H = 4;
    localparam int unsigned FLAG_X = 3;
    localparam int unsigned FLAG_P = 2;
    localparam int unsigned FLAG_N = 1;
    localparam int unsigned FLAG_C = 0;

    typedef struct packed {
        logic [OP_W-1:0]   operation;
        logic [WORD_W-1:0] operand_a;
        logic [WORD_W-1:0] operand_b;
        logic [BIT_W-1:0]  bit_index;
        logic [BYTE_W-1:0] flags_in;
    } t_alu_in;

    typedef struct packed {
        logic [WORD_W-1:0] result_value;
        logic [BYTE_W-1:0] flags_out;
    } t_alu_out;

    // sign, zero, y and x of a byte
    function automatic logic [BYTE_W-1:0] szxy(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] f;
        f         = '0;
        f[FLAG_S] = v[7];
        f[FLAG_Z] = (v == '0);
        f[FLAG_Y] = v[5];
        f[FLAG_X] = v[3];
        return f;
    endfunction

    // parity flag, set for even parity
    function automatic logic [BYTE_W-1:0] parity(input logic [BYTE_W-1:0] v);
        logic [BYTE_W-1:0] f;
        f         = '0;
        f[FLAG_P] = ~^v;
        return f;
    endfunction

endpackage

`default_nettype wire

// ----- sv/c8alu_core.sv -----
// c8alu_core: combinational datapath computing result value and flags for one item
// depends on c8alu_pkg
`timescale 1ns / 1ps
`default_nettype none

module c8alu_core (
    input  var c8alu_pkg::t_alu_in  i_item,
    output var c8alu_pkg::t_alu_out o_item
);

    logic [4:0]  opv;
    logic [7:0]  a;
    logic [7:0]  b;
    logic [7:0]  fin;
    logic        c;
    logic [15:0] a16;
    logic [15:0] b16;

    // 8-bit add
    logic        add_cin;
    logic [8:0]  sum9;
    logic [7:0]  f_add;

    // 8-bit subtract, shared by sub, sbc, cp and neg
    logic [7:0]  sub_a;
    logic [7:0]  sub_b;
    logic        sub_cin;
    logic [8:0]  diff9;
    logic [7:0]  f_sub;

    // rotates and shifts
    logic        rot_acc;
    logic [4:0]  rot_sel;
    logic [2:0]  rot_k;
    logic        rot_lo;
    logic        rot_hi;
    logic        rot_cout;
    logic [7:0]  rot_r;
    logic [7:0]  f_rot;

    // decimal adjust
    logic        daa_lo;
    logic        daa_hi;
    logic [7:0]  daa_diff;
    logic [7:0]  daa_r;
    logic        daa_h;

    // 16-bit
    logic        cin16;
    logic [16:0] sum17;
    logic [16:0] diff17;

    logic [7:0]  inc_r;
    logic [7:0]  dec_r;
    logic [7:0]  bit_mask;
    logic        bit_t;

    assign opv = i_item.operation;
    assign a   = i_item.operand_a[7:0];
    assign b   = i_item.operand_b[7:0];
    assign fin = i_item.flags_in;
    assign c   = fin[c8alu_pkg::FLAG_C];
    assign a16 = i_item.operand_a;
    assign b16 = i_item.operand_b;

    assign add_cin = (opv == c8alu_pkg::OP_ADC) ? c : 1'b0;
    assign sum9    = {1'b0, a} + {1'b0, b} + {8'b0, add_cin};
    always_comb begin
        f_add                      = c8alu_pkg::szxy(sum9[7:0]);
        f_add[c8alu_pkg::FLAG_H]   = a[4] ^ b[4] ^ sum9[4];
        f_add[c8alu_pkg::FLAG_P]   = (a[7] ^ sum9[7]) & (b[7] ^ sum9[7]);
        f_add[c8alu_pkg::FLAG_C]   = sum9[8];
    end

    assign sub_a   = (opv == c8alu_pkg::OP_NEG) ? 8'h00 : a;
    assign sub_b   = (opv == c8alu_pkg::OP_NEG) ? a : b;
    assign sub_cin = (opv == c8alu_pkg::OP_SBC) ? c : 1'b0;
    assign diff9   = {1'b0, sub_a} - {1'b0, sub_b} - {8'b0, sub_cin};
    always_comb begin
        f_sub                      = c8alu_pkg::szxy(diff9[7:0]);
        f_sub[c8alu_pkg::FLAG_H]   = sub_a[4] ^ sub_b[4] ^ diff9[4];
        f_sub[c8alu_pkg::FLAG_P]   = (sub_a[7] ^ sub_b[7]) & (sub_a[7] ^ diff9[7]);
        f_sub[c8alu_pkg::FLAG_N]   = 1'b1;
        f_sub[c8alu_pkg::FLAG_C]   = diff9[8];
    end

    assign rot_acc = (opv >= 5'(c8alu_pkg::OP_RLCA));
    assign rot_sel = rot_acc ? 5'(opv - 5'(c8alu_pkg::OP_RLCA))
                             : 5'(opv - 5'(c8alu_pkg::OP_RLC));
    assign rot_k   = rot_acc ? {1'b0, rot_sel[1:0]} : rot_sel[2:0];
    always_comb begin
        case (rot_k)
            3'd0:    rot_lo = a[7];
            3'd2:    rot_lo = c;
            3'd6:    rot_lo = 1'b1;
            default: rot_lo = 1'b0;
        endcase
        case (rot_k)
            3'd1:    rot_hi = a[0];
            3'd3:    rot_hi = c;
            3'd5:    rot_hi = a[7];
            default: rot_hi = 1'b0;
        endcase
        if (!rot_k[0]) begin
            rot_r    = {a[6:0], rot_lo};
            rot_cout = a[7];
        end else begin
            rot_r    = {rot_hi, a[7:1]};
            rot_cout = a[0];
        end
        if (rot_acc) begin
            f_rot                    = '0;
            f_rot[c8alu_pkg::FLAG_S] = fin[c8alu_pkg::FLAG_S];
            f_rot[c8alu_pkg::FLAG_Z] = fin[c8alu_pkg::FLAG_Z];
            f_rot[c8alu_pkg::FLAG_P] = fin[c8alu_pkg::FLAG_P];
            f_rot[c8alu_pkg::FLAG_Y] = rot_r[5];
            f_rot[c8alu_pkg::FLAG_X] = rot_r[3];
        end else begin
            f_rot = c8alu_pkg::szxy(rot_r) | c8alu_pkg::parity(rot_r);
        end
        f_rot[c8alu_pkg::FLAG_C] = rot_cout;
    end

    assign daa_lo   = (a[3:0] > 4'd9) || fin[c8alu_pkg::FLAG_H];
    assign daa_hi   = (a > 8'h99) || c;
    assign daa_diff = {1'b0, daa_hi, daa_hi, 1'b0, 1'b0, daa_lo, daa_lo, 1'b0};
    assign daa_r    = fin[c8alu_pkg::FLAG_N] ? (a - daa_diff) : (a + daa_diff);
    assign daa_h    = fin[c8alu_pkg::FLAG_N] ? (fin[c8alu_pkg::FLAG_H] && (a[3:0] < 4'd6))
                                             : (a[3:0] >= 4'd10);

    assign cin16  = (opv == c8alu_pkg::OP_ADC16) ? c : 1'b0;
    assign sum17  = {1'b0, a16} + {1'b0, b16} + {16'b0, cin16};
    assign diff17 = {1'b0, a16} - {1'b0, b16} - {16'b0, c};

    assign inc_r    = a + 8'd1;
    assign dec_r    = a - 8'd1;
    assign bit_mask = 8'd1 << i_item.bit_index;
    assign bit_t    = a[i_item.bit_index];

    always_comb begin
        logic [7:0]  r8;
        logic [15:0] r16;
        logic [7:0]  f;
        logic        wide;
        r8   = a;
        r16  = a16;
        f    = fin;
        wide = 1'b0;
        unique case (c8alu_pkg::t_alu_op'(opv)) inside
            c8alu_pkg::OP_ADD, c8alu_pkg::OP_ADC: begin
                r8 = sum9[7:0];
                f  = f_add;
            end
            c8alu_pkg::OP_SUB, c8alu_pkg::OP_SBC, c8alu_pkg::OP_NEG: begin
                r8 = diff9[7:0];
                f  = f_sub;
            end
            c8alu_pkg::OP_CP: begin
                r8                   = a;
                f                    = f_sub;
                f[c8alu_pkg::FLAG_Y] = b[5];
                f[c8alu_pkg::FLAG_X] = b[3];
            end
            c8alu_pkg::OP_AND: begin
                r8                   = a & b;
                f                    = c8alu_pkg::szxy(a & b) | c8alu_pkg::parity(a & b);
                f[c8alu_pkg::FLAG_H] = 1'b1;
            end
            c8alu_pkg::OP_OR: begin
                r8 = a | b;
                f  = c8alu_pkg::szxy(a | b) | c8alu_pkg::parity(a | b);
            end
            c8alu_pkg::OP_XOR: begin
                r8 = a ^ b;
                f  = c8alu_pkg::szxy(a ^ b) | c8alu_pkg::parity(a ^ b);
            end
            c8alu_pkg::OP_INC: begin
                r8                   = inc_r;
                f                    = c8alu_pkg::szxy(inc_r);
                f[c8alu_pkg::FLAG_H] = (a[3:0] == 4'hF);
                f[c8alu_pkg::FLAG_P] = (inc_r == 8'h80);
                f[c8alu_pkg::FLAG_C] = c;
            end
            c8alu_pkg::OP_DEC: begin
                r8                   = dec_r;
                f                    = c8alu_pkg::szxy(dec_r);
                f[c8alu_pkg::FLAG_H] = (a[3:0] == 4'h0);
                f[c8alu_pkg::FLAG_P] = (dec_r == 8'h7F);
                f[c8alu_pkg::FLAG_N] = 1'b1;
                f[c8alu_pkg::FLAG_C] = c;
            end
            c8alu_pkg::OP_CPL: begin
                r8                   = ~a;
                f                    = fin;
                f[c8alu_pkg::FLAG_H] = 1'b1;
                f[c8alu_pkg::FLAG_N] = 1'b1;
                f[c8alu_pkg::FLAG_Y] = ~a[5];
                f[c8alu_pkg::FLAG_X] = ~a[3];
            end
            c8alu_pkg::OP_DAA: begin
                r8                   = daa_r;
                f                    = c8alu_pkg::szxy(daa_r) | c8alu_pkg::parity(daa_r);
                f[c8alu_pkg::FLAG_H] = daa_h;
                f[c8alu_pkg::FLAG_N] = fin[c8alu_pkg::FLAG_N];
                f[c8alu_pkg::FLAG_C] = c | daa_hi;
            end
            c8alu_pkg::OP_RLC, c8alu_pkg::OP_RRC, c8alu_pkg::OP_RL, c8alu_pkg::OP_RR,
            c8alu_pkg::OP_SLA, c8alu_pkg::OP_SRA, c8alu_pkg::OP_SLL, c8alu_pkg::OP_SRL,
            c8alu_pkg::OP_RLCA, c8alu_pkg::OP_RRCA, c8alu_pkg::OP_RLA,
            c8alu_pkg::OP_RRA: begin
                r8 = rot_r;
                f  = f_rot;
            end
            c8alu_pkg::OP_BIT: begin
                r8                   = a;
                f                    = '0;
                f[c8alu_pkg::FLAG_S] = bit_t && (i_item.bit_index == 3'd7);
                f[c8alu_pkg::FLAG_Z] = !bit_t;
                f[c8alu_pkg::FLAG_P] = !bit_t;
                f[c8alu_pkg::FLAG_H] = 1'b1;
                f[c8alu_pkg::FLAG_C] = c;
                f[c8alu_pkg::FLAG_Y] = a[5];
                f[c8alu_pkg::FLAG_X] = a[3];
            end
            c8alu_pkg::OP_RES: begin
                r8 = a & ~bit_mask;
            end
            c8alu_pkg::OP_SET: begin
                r8 = a | bit_mask;
            end
            c8alu_pkg::OP_CCF: begin
                r8                   = a;
                f                    = fin;
                f[c8alu_pkg::FLAG_H] = c;
                f[c8alu_pkg::FLAG_N] = 1'b0;
                f[c8alu_pkg::FLAG_C] = !c;
                f[c8alu_pkg::FLAG_Y] = a[5];
                f[c8alu_pkg::FLAG_X] = a[3];
            end
            c8alu_pkg::OP_ADD16, c8alu_pkg::OP_ADC16: begin
                wide                 = 1'b1;
                r16                  = sum17[15:0];
                f                    = fin;
                f[c8alu_pkg::FLAG_H] = a16[12] ^ b16[12] ^ sum17[12];
                f[c8alu_pkg::FLAG_N] = 1'b0;
                f[c8alu_pkg::FLAG_C] = sum17[16];
                f[c8alu_pkg::FLAG_Y] = sum17[13];
                f[c8alu_pkg::FLAG_X] = sum17[11];
                if (opv == c8alu_pkg::OP_ADC16) begin
                    f[c8alu_pkg::FLAG_S] = sum17[15];
                    f[c8alu_pkg::FLAG_Z] = (sum17[15:0] == 16'h0000);
                    f[c8alu_pkg::FLAG_P] = (a16[15] ^ sum17[15]) & (b16[15] ^ sum17[15]);
                end
            end
            c8alu_pkg::OP_SBC16: begin
                wide                 = 1'b1;
                r16                  = diff17[15:0];
                f                    = '0;
                f[c8alu_pkg::FLAG_S] = diff17[15];
                f[c8alu_pkg::FLAG_Z] = (diff17[15:0] == 16'h0000);
                f[c8alu_pkg::FLAG_N] = 1'b1;
                f[c8alu_pkg::FLAG_H] = a16[12] ^ b16[12] ^ diff17[12];
                f[c8alu_pkg::FLAG_C] = diff17[16];
                f[c8alu_pkg::FLAG_P] = (a16[15] ^ b16[15]) & (a16[15] ^ diff17[15]);
                f[c8alu_pkg::FLAG_Y] = diff17[13];
                f[c8alu_pkg::FLAG_X] = diff17[11];
            end
            default: begin
                r8 = a;
                f  = fin;
            end
        endcase
        o_item.result_value = wide ? r16 : {8'h00, r8};
        o_item.flags_out    = f;
    end

endmodule

`default_nettype wire

// ----- sv/cpu8_alu_with_flags_unit.sv -----
// path: item accept to o_valid passes the input register, then the result register
// throughput: one item per cycle; o_stall rises only when both stages hold items
// and i_stall is high
// reset: synchronous active-low i_rst_n clears both stage valid bits, payload is not reset
// top level of the 8-bit alu with flags; uses c8alu_pkg and c8alu_core
`timescale 1ns / 1ps
`default_nettype none

module cpu8_alu_with_flags_unit (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         i_valid,
    output logic        o_stall,
    input  wire  [4:0]  i_operation,
    input  wire  [15:0] i_operand_a,
    input  wire  [15:0] i_operand_b,
    input  wire  [2:0]  i_bit_index,
    input  wire  [7:0]  i_flags_in,
    output logic        o_valid,
    input  wire         i_stall,
    output logic [15:0] o_result_value,
    output logic [7:0]  o_flags_out
);

    logic                 r_in_valid;
    logic                 n_in_valid;
    c8alu_pkg::t_alu_in   r_in;
    logic                 r_out_valid;
    logic                 n_out_valid;
    c8alu_pkg::t_alu_out  r_out;
    c8alu_pkg::t_alu_out  n_out;
    logic                 out_adv;
    logic                 in_adv;
    logic                 in_take;

    assign out_adv = !r_out_valid || !i_stall;
    assign in_adv  = !r_in_valid || out_adv;
    assign in_take = i_valid && in_adv;
    assign o_stall = !in_adv;

    assign n_in_valid  = in_adv ? i_valid : r_in_valid;
    assign n_out_valid = out_adv ? r_in_valid : r_out_valid;

    c8alu_core u_core (
        .i_item (r_in),
        .o_item (n_out)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in.operation <= i_operation;
            r_in.operand_a <= i_operand_a;
            r_in.operand_b <= i_operand_b;
            r_in.bit_index <= i_bit_index;
            r_in.flags_in  <= i_flags_in;
        end
        if (out_adv && r_in_valid) begin
            r_out <= n_out;
        end
    end

    assign o_valid        = r_out_valid;
    assign o_result_value = r_out.result_value;
    assign o_flags_out    = r_out.flags_out;

endmodule

`default_nettype wire

// ----- sv/c8alu_checker.sv -----
// c8alu_checker: port-level assertions for cpu8_alu_with_flags_unit
// bound to the top level below; no package dependencies
`timescale 1ns / 1ps
`default_nettype none

module c8alu_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        i_valid,
    input wire        o_stall,
    input wire [4:0]  i_operation,
    input wire [15:0] i_operand_a,
    input wire [15:0] i_operand_b,
    input wire [2:0]  i_bit_index,
    input wire [7:0]  i_flags_in,
    input wire        o_valid,
    input wire        i_stall,
    input wire [15:0] o_result_value,
    input wire [7:0]  o_flags_out
);

    // nothing comes out right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("o_valid high right after reset");

    // backpressure only when the output stage is full and blocked
    a_stall_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall))
        else $error("o_stall without a blocked output item");

    // an accepted item reaches the output when output flows
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) ##1 !i_stall |=> o_valid)
        else $error("accepted item did not reach the output");

    // stalled output item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_stall) |=>
            (o_valid && $stable(o_result_value) && $stable(o_flags_out)))
        else $error("stalled output item changed");

endmodule

bind cpu8_alu_with_flags_unit c8alu_checker u_c8alu_checker (.*);

`default_nettype wire
